### hw/rtl/tsgd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Swipe gesture detector package
// Event codes, fixed zone edges, register indexes and the result type.
// ----------------------------------------------------------------------------
package tsgd_pkg;

	typedef enum logic [2:0] {
		OP_SLOT  = 3'd0,
		OP_TRACK = 3'd1,
		OP_POS_X = 3'd2,
		OP_POS_Y = 3'd3,
		OP_OTHER = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		REG_ENABLE     = 3'd0,
		REG_VIB_ENABLE = 3'd1,
		REG_VIB_MS     = 3'd2,
		REG_BOTTOM_Y   = 3'd3,
		REG_TOP_Y      = 3'd4,
		REG_LEFT_X     = 3'd5,
		REG_RIGHT_X    = 3'd6
	} reg_index_t;

	localparam int VALUE_W   = 16;
	localparam int EDGE_W    = 12;
	localparam int VIB_W     = 7;
	localparam int CFG_DATA_W = 12;

	localparam int EDGE_RL_MID = 750;
	localparam int EDGE_RL_LOW = 450;
	localparam int EDGE_LR_LOW = 350;
	localparam int EDGE_LR_MID = 630;

	localparam logic [VIB_W-1:0] VIB_MIN_MS = 7'd18;
	localparam logic [VIB_W-1:0] VIB_MAX_MS = 7'd100;

	localparam logic [VIB_W-1:0]  RST_VIB_MS   = 7'd30;
	localparam logic [EDGE_W-1:0] RST_BOTTOM_Y = 12'd1790;
	localparam logic [EDGE_W-1:0] RST_TOP_Y    = 12'd100;
	localparam logic [EDGE_W-1:0] RST_LEFT_X   = 12'd200;
	localparam logic [EDGE_W-1:0] RST_RIGHT_X  = 12'd880;

	typedef struct packed {
		logic             trigger;
		logic             vibrate;
		logic [VIB_W-1:0] vibrate_time;
	} result_t;

endpackage
`default_nettype wire

### hw/rtl/tsgd_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Swipe gesture detector channels
// Touch event channel and result channel, each with valid and ready.
// ----------------------------------------------------------------------------
interface tsgd_in_if;
	logic                             valid;
	logic                             ready;
	logic [2:0]                       op;
	logic signed [tsgd_pkg::VALUE_W-1:0] value;

	modport source (output valid, output op, output value, input ready);
	modport sink (input valid, input op, input value, output ready);
endinterface

interface tsgd_out_if;
	logic                           valid;
	logic                           ready;
	logic                           trigger;
	logic                           vibrate;
	logic [tsgd_pkg::VIB_W-1:0]     vibrate_time;

	modport source (output valid, output trigger, output vibrate, output vibrate_time,
		input ready);
	modport sink (input valid, input trigger, input vibrate, input vibrate_time,
		output ready);
endinterface
`default_nettype wire

### hw/rtl/tsgd_chain.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Swipe chain
// Three-zone swipe chain with two sticky zone flags, right-to-left or
// left-to-right.
// ----------------------------------------------------------------------------
module tsgd_chain #(
	parameter int CMP_W = 29,
	parameter bit RTL   = 1'b1
) (
	input  wire logic signed [CMP_W-1:0]            x,
	input  wire logic                               band,
	input  wire logic [tsgd_pkg::EDGE_W-1:0]        left_edge,
	input  wire logic [tsgd_pkg::EDGE_W-1:0]        right_edge,
	input  wire logic [1:0]                         prog,
	output logic      [1:0]                         prog_next,
	output logic                                    done
);

	logic signed [CMP_W-1:0] left_s;
	logic signed [CMP_W-1:0] right_s;
	logic signed [CMP_W-1:0] mid_s;
	logic signed [CMP_W-1:0] low_s;
	logic                    z1;
	logic                    z2;
	logic                    z3;
	logic                    f0;
	logic                    f1;

	assign left_s  = $signed({{(CMP_W-tsgd_pkg::EDGE_W){1'b0}}, left_edge});
	assign right_s = $signed({{(CMP_W-tsgd_pkg::EDGE_W){1'b0}}, right_edge});

	always_comb begin
		if (RTL) begin
			mid_s = $signed(CMP_W'(tsgd_pkg::EDGE_RL_MID));
			low_s = $signed(CMP_W'(tsgd_pkg::EDGE_RL_LOW));
			z1 = band && (x < right_s) && (x > mid_s);
			z2 = band && (x < mid_s) && (x > low_s);
			z3 = band && (x < low_s) && (x < left_s);
		end else begin
			mid_s = $signed(CMP_W'(tsgd_pkg::EDGE_LR_MID));
			low_s = $signed(CMP_W'(tsgd_pkg::EDGE_LR_LOW));
			z1 = band && (x > left_s) && (x < low_s);
			z2 = band && (x > low_s) && (x < mid_s);
			z3 = band && (x > mid_s) && (x > right_s);
		end
	end

	assign f0        = prog[0] | z1;
	assign f1        = prog[1] | (f0 & z2);
	assign prog_next = {f1, f0};
	assign done      = f0 & f1 & z3;

endmodule
`default_nettype wire

### hw/rtl/touch_swipe_gesture_detector.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Touch swipe gesture detector
// Tracks touch events and requests a power-key press when a three-zone
// swipe along the top or bottom band completes.
//
//   Channel  Direction  Contents
//   evt      in         op, value (one touch event per beat)
//   res      out        trigger, vibrate, vibrate_time (one per event)
//   cfg      in         cfg_we, cfg_index, cfg_data (register writes)
//
// Each event is evaluated in the cycle it is accepted and its result is
// registered, so one event per cycle is taken while the event channel is
// not stalled. While a result is held, a second output register takes one
// more event; the event channel then stalls and resumes in the cycle after
// the held result is taken. After reset the block is ready at once with the
// listed defaults.
// ----------------------------------------------------------------------------
module touch_swipe_gesture_detector #(
	parameter int COORD_BITS = 16
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	tsgd_in_if.sink                                   evt,
	tsgd_out_if.source                                res,
	input  wire logic                                 cfg_we,
	input  wire logic [2:0]                           cfg_index,
	input  wire logic [tsgd_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int CMP_W = COORD_BITS + tsgd_pkg::EDGE_W + 1;

	logic                              enable_q;
	logic                              vib_enable_q;
	logic [tsgd_pkg::VIB_W-1:0]        vib_ms_q;
	logic [tsgd_pkg::EDGE_W-1:0]       bottom_y_q;
	logic [tsgd_pkg::EDGE_W-1:0]       top_y_q;
	logic [tsgd_pkg::EDGE_W-1:0]       left_x_q;
	logic [tsgd_pkg::EDGE_W-1:0]       right_x_q;

	logic signed [COORD_BITS-1:0]      last_x_q;
	logic signed [COORD_BITS-1:0]      last_y_q;
	logic                              x_seen_q;
	logic                              y_seen_q;
	logic                              armed_q;
	logic [1:0]                        prog_q [4];
	logic [1:0]                        prog_next [4];
	logic [3:0]                        chain_done;

	logic signed [COORD_BITS-1:0]      coord;
	logic signed [COORD_BITS-1:0]      x_cur;
	logic signed [COORD_BITS-1:0]      y_cur;
	logic signed [CMP_W-1:0]           x_ext;
	logic signed [CMP_W-1:0]           y_ext;
	logic                              band_bot;
	logic                              band_top;
	logic                              is_x;
	logic                              is_y;
	logic                              clear_evt;
	logic                              eval;
	logic                              fire;
	logic                              accept;
	logic [tsgd_pkg::VIB_W-1:0]        cfg_vib;
	tsgd_pkg::result_t                 result;

	logic                              out_valid_q;
	tsgd_pkg::result_t                 out_data_q;
	logic                              skid_valid_q;
	tsgd_pkg::result_t                 skid_data_q;

	generate
		if (COORD_BITS >= tsgd_pkg::VALUE_W) begin : g_wide
			assign coord = COORD_BITS'(evt.value);
		end else begin : g_narrow
			assign coord = $signed(evt.value[COORD_BITS-1:0]);
		end
	endgenerate

	assign accept    = evt.valid && evt.ready;
	assign evt.ready = !skid_valid_q;

	assign is_x      = evt.op == tsgd_pkg::OP_POS_X;
	assign is_y      = evt.op == tsgd_pkg::OP_POS_Y;
	assign clear_evt = (evt.op == tsgd_pkg::OP_SLOT) ||
		((evt.op == tsgd_pkg::OP_TRACK) && (evt.value == -16'sd1));

	assign x_cur = is_x ? coord : last_x_q;
	assign y_cur = is_y ? coord : last_y_q;
	assign x_ext = CMP_W'(x_cur);
	assign y_ext = CMP_W'(y_cur);

	assign band_bot = y_ext > $signed({{(CMP_W-tsgd_pkg::EDGE_W){1'b0}}, bottom_y_q});
	assign band_top = y_ext < $signed({{(CMP_W-tsgd_pkg::EDGE_W){1'b0}}, top_y_q});

	assign eval = !clear_evt && (x_seen_q || is_x) && (y_seen_q || is_y);
	assign fire = eval && enable_q && armed_q && (|chain_done);

	tsgd_chain #(.CMP_W(CMP_W), .RTL(1'b1)) u_chain_bot_rl (
		.x(x_ext), .band(band_bot), .left_edge(left_x_q), .right_edge(right_x_q),
		.prog(prog_q[0]), .prog_next(prog_next[0]), .done(chain_done[0])
	);
	tsgd_chain #(.CMP_W(CMP_W), .RTL(1'b0)) u_chain_bot_lr (
		.x(x_ext), .band(band_bot), .left_edge(left_x_q), .right_edge(right_x_q),
		.prog(prog_q[1]), .prog_next(prog_next[1]), .done(chain_done[1])
	);
	tsgd_chain #(.CMP_W(CMP_W), .RTL(1'b1)) u_chain_top_rl (
		.x(x_ext), .band(band_top), .left_edge(left_x_q), .right_edge(right_x_q),
		.prog(prog_q[2]), .prog_next(prog_next[2]), .done(chain_done[2])
	);
	tsgd_chain #(.CMP_W(CMP_W), .RTL(1'b0)) u_chain_top_lr (
		.x(x_ext), .band(band_top), .left_edge(left_x_q), .right_edge(right_x_q),
		.prog(prog_q[3]), .prog_next(prog_next[3]), .done(chain_done[3])
	);

	always_comb begin
		result.trigger      = fire;
		result.vibrate      = fire && vib_enable_q;
		result.vibrate_time = (fire && vib_enable_q) ? vib_ms_q : '0;
	end

	assign cfg_vib = cfg_data[tsgd_pkg::VIB_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q     <= 1'b1;
			vib_enable_q <= 1'b0;
			vib_ms_q     <= tsgd_pkg::RST_VIB_MS;
			bottom_y_q   <= tsgd_pkg::RST_BOTTOM_Y;
			top_y_q      <= tsgd_pkg::RST_TOP_Y;
			left_x_q     <= tsgd_pkg::RST_LEFT_X;
			right_x_q    <= tsgd_pkg::RST_RIGHT_X;
		end else if (cfg_we) begin
			case (cfg_index)
				tsgd_pkg::REG_ENABLE:     enable_q     <= cfg_data[0];
				tsgd_pkg::REG_VIB_ENABLE: vib_enable_q <= cfg_data[0];
				tsgd_pkg::REG_VIB_MS: begin
					if (cfg_vib >= tsgd_pkg::VIB_MIN_MS && cfg_vib <= tsgd_pkg::VIB_MAX_MS) begin
						vib_ms_q <= cfg_vib;
					end
				end
				tsgd_pkg::REG_BOTTOM_Y:   bottom_y_q   <= cfg_data;
				tsgd_pkg::REG_TOP_Y:      top_y_q      <= cfg_data;
				tsgd_pkg::REG_LEFT_X:     left_x_q     <= cfg_data;
				tsgd_pkg::REG_RIGHT_X:    right_x_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_x_q <= '0;
			last_y_q <= '0;
			x_seen_q <= 1'b0;
			y_seen_q <= 1'b0;
			armed_q  <= 1'b1;
			for (int i = 0; i < 4; i++) begin
				prog_q[i] <= '0;
			end
		end else if (accept) begin
			if (clear_evt) begin
				armed_q <= 1'b1;
				for (int i = 0; i < 4; i++) begin
					prog_q[i] <= '0;
				end
			end else begin
				last_x_q <= x_cur;
				last_y_q <= y_cur;
				if (eval) begin
					x_seen_q <= 1'b0;
					y_seen_q <= 1'b0;
					if (enable_q) begin
						for (int i = 0; i < 4; i++) begin
							prog_q[i] <= prog_next[i];
						end
						if (|chain_done) begin
							armed_q <= 1'b0;
						end
					end
				end else begin
					x_seen_q <= x_seen_q || is_x;
					y_seen_q <= y_seen_q || is_y;
				end
			end
		end
	end

	// The skid entry only fills while the output register is held.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || res.ready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= accept;
			end
		end else if (accept) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || res.ready) begin
			if (skid_valid_q) begin
				out_data_q <= skid_data_q;
			end else if (accept) begin
				out_data_q <= result;
			end
		end else if (accept) begin
			skid_data_q <= result;
		end
	end

	assign res.valid        = out_valid_q;
	assign res.trigger      = out_data_q.trigger;
	assign res.vibrate      = out_data_q.vibrate;
	assign res.vibrate_time = out_data_q.vibrate_time;

endmodule
`default_nettype wire
